// ===== hw/rtl/all_pkg.sv =====
package all_pkg;

    localparam int NODES      = 64;
    localparam int DATA_WIDTH = 16;
    localparam int AW         = $clog2(NODES);
    localparam int LW         = $clog2(NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(NODES);

    localparam logic [3:0] M_INS_HEAD   = 4'd0;
    localparam logic [3:0] M_INS_TAIL   = 4'd1;
    localparam logic [3:0] M_REMOVE     = 4'd2;
    localparam logic [3:0] M_INS_AFTER  = 4'd3;
    localparam logic [3:0] M_INS_BEFORE = 4'd4;
    localparam logic [3:0] M_RM_HEAD    = 4'd5;
    localparam logic [3:0] M_RM_TAIL    = 4'd6;
    localparam logic [3:0] M_RM_AFTER   = 4'd7;
    localparam logic [3:0] M_RM_BEFORE  = 4'd8;
    localparam logic [3:0] M_DUMP       = 4'd9;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_DUMP     = 3'd4;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_RDCUR,
        CMD_WALK,
        CMD_DWALK,
        CMD_MARK,
        CMD_RD_FREE,
        CMD_ALLOC,
        CMD_LINK_X,
        CMD_UNLINK,
        CMD_RD_NEXT,
        CMD_SPLICE,
        CMD_GIVE
    } t_cmd;

    typedef struct packed {
        logic [3:0] mode;
        logic       empty;
        logic       free_empty;
        logic       match;
        logic       at_end;
        logic       prev_nil;
        logic       next_nil;
    } t_sts;

endpackage

// ===== hw/rtl/array_linked_list_engine.sv =====
// channel   | handshake        | beat
// ----------+------------------+----------------------------------
// command   | start, busy      | i_mode, i_key, i_value
// result    | o_strobe         | o_status, o_data, o_last
//
// a command is taken when start is high and busy is low
// an op is paced by the list walk, which visits one node at a time
// through the single read port of the node store
// a dump gives one result beat per node, one per cycle
// synchronous active-low reset; no clearing pass, link entries default until written
// result beats last one cycle each and cannot be held off
module array_linked_list_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [3:0]                     i_mode,
    input  logic [all_pkg::DATA_WIDTH-1:0] i_key,
    input  logic [all_pkg::DATA_WIDTH-1:0] i_value,
    output logic                           o_strobe,
    output logic [2:0]                     o_status,
    output logic [all_pkg::DATA_WIDTH-1:0] o_data,
    output logic                           o_last
);
    import all_pkg::*;

    t_cmd cmd;
    t_sts sts;

    all_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_status (o_status),
        .o_last   (o_last)
    );

    all_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_mode  (i_mode),
        .i_key   (i_key),
        .i_value (i_value),
        .o_sts   (sts),
        .o_data  (o_data)
    );

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_DUMP |-> o_last)
        else $error("non-dump beat without last");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_DUMP |-> o_data == '0)
        else $error("non-dump beat with data");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("busy after final beat");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command taken without going busy");

endmodule

// ===== hw/rtl/all_datapath.sv =====
module all_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  all_pkg::t_cmd                  i_cmd,
    input  logic [3:0]                     i_mode,
    input  logic [all_pkg::DATA_WIDTH-1:0] i_key,
    input  logic [all_pkg::DATA_WIDTH-1:0] i_value,
    output all_pkg::t_sts                  o_sts,
    output logic [all_pkg::DATA_WIDTH-1:0] o_data
);
    import all_pkg::*;

    logic [LW-1:0]         r_link_mem [NODES];
    logic [DATA_WIDTH-1:0] r_val_mem  [NODES];
    logic [NODES-1:0]      r_lv;

    logic [LW-1:0]         r_used, r_free, r_cur, r_prev, r_pprev, r_cnext, r_x;
    logic [3:0]            r_mode;
    logic [DATA_WIDTH-1:0] r_key, r_val, r_data;
    logic [LW-1:0]         r_rd_raw;
    logic [DATA_WIDTH-1:0] r_rd_val;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_rd_vld;

    logic [LW-1:0]         rd_link;
    logic [AW-1:0]         ra;
    logic                  lk_we, vl_we;
    logic [AW-1:0]         lk_wa;
    logic [LW-1:0]         lk_wd;
    logic [LW-1:0]         sel_tgt, sel_dat, give_n, alloc_lk;
    logic [DATA_WIDTH-1:0] target;

    assign rd_link = r_rd_vld ? r_rd_raw : LW'(r_rd_addr) + LW'(1);
    assign target  = (r_mode == M_REMOVE) ? r_val : r_key;

    assign o_sts.mode       = r_mode;
    assign o_sts.empty      = (r_used == NIL);
    assign o_sts.free_empty = (r_free == NIL);
    assign o_sts.match      = (r_rd_val == target);
    assign o_sts.at_end     = (rd_link == NIL);
    assign o_sts.prev_nil   = (r_prev == NIL);
    assign o_sts.next_nil   = (r_cnext == NIL);
    assign o_data           = r_data;

    always_comb begin
        sel_tgt = r_cur;
        sel_dat = r_x;
        if (i_cmd == CMD_UNLINK) begin
            if (r_mode == M_RM_BEFORE) begin
                sel_tgt = r_pprev;
                sel_dat = r_cur;
            end else begin
                sel_tgt = r_prev;
                sel_dat = r_cnext;
            end
        end else if (r_mode == M_INS_BEFORE) begin
            sel_tgt = r_prev;
        end
        if (r_mode == M_RM_AFTER) begin
            give_n = r_cnext;
        end else if (r_mode == M_RM_BEFORE) begin
            give_n = r_prev;
        end else begin
            give_n = r_cur;
        end
        case (r_mode)
            M_INS_HEAD:   alloc_lk = r_used;
            M_INS_AFTER:  alloc_lk = r_cnext;
            M_INS_BEFORE: alloc_lk = r_cur;
            default:      alloc_lk = NIL;
        endcase
    end

    always_comb begin
        lk_we = 1'b0;
        vl_we = 1'b0;
        lk_wa = r_cur[AW-1:0];
        lk_wd = r_x;
        ra    = r_cur[AW-1:0];
        unique case (i_cmd)
            CMD_WALK, CMD_DWALK: ra = rd_link[AW-1:0];
            CMD_RD_FREE:         ra = r_free[AW-1:0];
            CMD_RD_NEXT:         ra = r_cnext[AW-1:0];
            CMD_ALLOC: begin
                lk_we = 1'b1;
                vl_we = 1'b1;
                lk_wa = r_free[AW-1:0];
                lk_wd = alloc_lk;
            end
            CMD_LINK_X, CMD_UNLINK: begin
                lk_we = (sel_tgt != NIL);
                lk_wa = sel_tgt[AW-1:0];
                lk_wd = sel_dat;
            end
            CMD_SPLICE: begin
                lk_we = 1'b1;
                lk_wd = rd_link;
            end
            CMD_GIVE: begin
                lk_we = 1'b1;
                lk_wa = give_n[AW-1:0];
                lk_wd = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) r_link_mem[lk_wa] <= lk_wd;
        if (vl_we) r_val_mem[lk_wa] <= r_val;
        r_rd_raw  <= r_link_mem[ra];
        r_rd_val  <= r_val_mem[ra];
        r_rd_vld  <= r_lv[ra];
        r_rd_addr <= ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv   <= '0;
            r_used <= NIL;
            r_free <= '0;
        end else begin
            if (lk_we) r_lv[lk_wa] <= 1'b1;
            unique case (i_cmd)
                CMD_ALLOC: begin
                    r_free <= rd_link;
                    if (r_mode == M_INS_HEAD || (r_mode == M_INS_TAIL && r_used == NIL)) begin
                        r_used <= r_free;
                    end
                end
                CMD_LINK_X, CMD_UNLINK: if (sel_tgt == NIL) r_used <= sel_dat;
                CMD_GIVE: r_free <= give_n;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= (i_cmd == CMD_DWALK) ? r_rd_val : '0;
        unique case (i_cmd)
            CMD_LOAD: begin
                r_mode  <= i_mode;
                r_key   <= i_key;
                r_val   <= i_value;
                r_cur   <= r_used;
                r_prev  <= NIL;
                r_pprev <= NIL;
            end
            CMD_WALK, CMD_DWALK: begin
                r_pprev <= r_prev;
                r_prev  <= r_cur;
                r_cur   <= rd_link;
            end
            CMD_MARK:  r_cnext <= rd_link;
            CMD_ALLOC: r_x <= r_free;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/all_controller.sv =====
module all_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  all_pkg::t_sts i_sts,
    output all_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_strobe,
    output logic [2:0]    o_status,
    output logic          o_last
);
    import all_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_WALK, S_FOUND, S_ALLOC, S_LINK, S_SPLICE, S_GIVE
    } t_state;

    t_state     r_state, n_state;
    logic       r_strobe, n_strobe, r_last, n_last, r_solo, n_solo;
    logic [2:0] r_status, n_status;
    t_cmd       cmd;

    assign o_cmd    = cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_last   = r_last;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_last   = 1'b1;
        n_solo   = r_solo;
        cmd      = CMD_NOP;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                cmd     = CMD_LOAD;
                n_solo  = 1'b0;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                case (i_sts.mode) inside
                    M_INS_HEAD: begin
                        if (i_sts.free_empty) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                            n_state  = S_IDLE;
                        end else begin
                            cmd     = CMD_RD_FREE;
                            n_state = S_ALLOC;
                        end
                    end
                    M_INS_TAIL: begin
                        if (i_sts.free_empty) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                            n_state  = S_IDLE;
                        end else if (i_sts.empty) begin
                            cmd     = CMD_RD_FREE;
                            n_solo  = 1'b1;
                            n_state = S_ALLOC;
                        end else begin
                            cmd     = CMD_RDCUR;
                            n_state = S_WALK;
                        end
                    end
                    [M_REMOVE:M_DUMP]: begin
                        if (i_sts.empty) begin
                            n_strobe = 1'b1;
                            n_status = ST_EMPTY;
                            n_state  = S_IDLE;
                        end else begin
                            cmd     = CMD_RDCUR;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                case (i_sts.mode) inside
                    M_DUMP: begin
                        cmd      = CMD_DWALK;
                        n_strobe = 1'b1;
                        n_status = ST_DUMP;
                        n_last   = i_sts.at_end;
                        if (i_sts.at_end) n_state = S_IDLE;
                    end
                    M_RM_HEAD: begin
                        cmd     = CMD_MARK;
                        n_state = S_FOUND;
                    end
                    M_INS_TAIL, M_RM_TAIL: begin
                        if (i_sts.at_end) begin
                            cmd     = CMD_MARK;
                            n_state = S_FOUND;
                        end else begin
                            cmd = CMD_WALK;
                        end
                    end
                    default: begin
                        if (i_sts.match) begin
                            cmd     = CMD_MARK;
                            n_state = S_FOUND;
                        end else if (i_sts.at_end) begin
                            n_strobe = 1'b1;
                            n_status = ST_NOTFOUND;
                            n_state  = S_IDLE;
                        end else begin
                            cmd = CMD_WALK;
                        end
                    end
                endcase
            end
            S_FOUND: begin
                case (i_sts.mode) inside
                    M_INS_TAIL, M_INS_AFTER, M_INS_BEFORE: begin
                        if (i_sts.free_empty) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                            n_state  = S_IDLE;
                        end else begin
                            cmd     = CMD_RD_FREE;
                            n_state = S_ALLOC;
                        end
                    end
                    M_RM_AFTER: begin
                        if (i_sts.next_nil) begin
                            n_strobe = 1'b1;
                            n_status = ST_NOTFOUND;
                            n_state  = S_IDLE;
                        end else begin
                            cmd     = CMD_RD_NEXT;
                            n_state = S_SPLICE;
                        end
                    end
                    M_RM_BEFORE: begin
                        if (i_sts.prev_nil) begin
                            n_strobe = 1'b1;
                            n_status = ST_NOTFOUND;
                            n_state  = S_IDLE;
                        end else begin
                            cmd     = CMD_UNLINK;
                            n_state = S_GIVE;
                        end
                    end
                    default: begin
                        cmd     = CMD_UNLINK;
                        n_state = S_GIVE;
                    end
                endcase
            end
            S_SPLICE: begin
                cmd     = CMD_SPLICE;
                n_state = S_GIVE;
            end
            S_GIVE: begin
                cmd      = CMD_GIVE;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_ALLOC: begin
                cmd = CMD_ALLOC;
                if (i_sts.mode == M_INS_HEAD || r_solo) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                cmd      = CMD_LINK_X;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_status <= ST_OK;
            r_last   <= 1'b0;
            r_solo   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_status <= n_status;
            r_last   <= n_last;
            r_solo   <= n_solo;
        end
    end

endmodule

// ===== test/array_linked_list_engine_test.sv =====
`timescale 1ns / 100ps

module array_linked_list_engine_test;
    import all_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]            status;
        logic [DATA_WIDTH-1:0] data;
        logic                  last;
    } t_result_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [3:0]            i_mode = '0;
    logic [DATA_WIDTH-1:0] i_key = '0;
    logic [DATA_WIDTH-1:0] i_value = '0;
    logic                  o_strobe;
    logic [2:0]            o_status;
    logic [DATA_WIDTH-1:0] o_data;
    logic                  o_last;

    array_linked_list_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_key(i_key), .i_value(i_value),
        .o_strobe(o_strobe), .o_status(o_status), .o_data(o_data), .o_last(o_last)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    logic [LW-1:0]         node_link [NODES];
    logic [DATA_WIDTH-1:0] node_val [NODES];
    logic [LW-1:0]         list_head;
    logic [LW-1:0]         free_head;
    t_result_beat          pending_beats [$];
    int                    errors = 0;
    int                    stall_count = 0;
    bit                    gaps_on = 1'b1;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task automatic list_reset();
        for (int i = 0; i < NODES; i++) begin
            node_link[i] = LW'(i + 1);
            node_val[i] = '0;
        end
        list_head = NIL;
        free_head = '0;
    endtask

    function automatic logic [LW-1:0] alloc_node(input logic [DATA_WIDTH-1:0] v);
        logic [LW-1:0] x;
        x = free_head;
        if (x == NIL) return NIL;
        free_head = node_link[x];
        node_val[x] = v;
        node_link[x] = NIL;
        return x;
    endfunction

    function automatic void unlink_node(input logic [LW-1:0] p, input logic [LW-1:0] c);
        if (p == NIL) list_head = node_link[c];
        else node_link[p] = node_link[c];
        node_link[c] = free_head;
        free_head = c;
    endfunction

    function automatic void find_first(input logic [DATA_WIDTH-1:0] v,
                                       output logic [LW-1:0] c, output logic [LW-1:0] p);
        logic [LW-1:0] prev, cur;
        prev = NIL;
        cur = list_head;
        c = NIL;
        p = NIL;
        for (int n = 0; n < NODES && cur != NIL; n++) begin
            if (node_val[cur] == v) begin
                c = cur;
                p = prev;
                return;
            end
            prev = cur;
            cur = node_link[cur];
        end
    endfunction

    task automatic predict_op(input logic [3:0] mode, input logic [DATA_WIDTH-1:0] key,
                              input logic [DATA_WIDTH-1:0] val);
        logic [LW-1:0] c, p, x, q, pp;
        logic [2:0]    st;
        st = ST_OK;
        if (mode == M_DUMP) begin
            if (list_head == NIL) begin
                pending_beats.push_back('{ST_EMPTY, '0, 1'b1});
            end else begin
                c = list_head;
                for (int n = 0; n < NODES && c != NIL; n++) begin
                    pending_beats.push_back('{ST_DUMP, node_val[c],
                        (node_link[c] == NIL || n + 1 >= NODES)});
                    c = node_link[c];
                end
            end
            return;
        end
        case (mode)
            M_INS_HEAD, M_INS_TAIL: begin
                x = alloc_node(val);
                if (x == NIL) st = ST_FULL;
                else if (mode == M_INS_HEAD) begin
                    node_link[x] = list_head;
                    list_head = x;
                end else if (list_head == NIL) list_head = x;
                else begin
                    c = list_head;
                    while (node_link[c] != NIL) c = node_link[c];
                    node_link[c] = x;
                end
            end
            M_REMOVE: begin
                if (list_head == NIL) st = ST_EMPTY;
                else begin
                    find_first(val, c, p);
                    if (c == NIL) st = ST_NOTFOUND;
                    else unlink_node(p, c);
                end
            end
            M_INS_AFTER, M_INS_BEFORE: begin
                if (list_head == NIL) st = ST_EMPTY;
                else begin
                    find_first(key, c, p);
                    if (c == NIL) st = ST_NOTFOUND;
                    else begin
                        x = alloc_node(val);
                        if (x == NIL) st = ST_FULL;
                        else if (mode == M_INS_AFTER) begin
                            node_link[x] = node_link[c];
                            node_link[c] = x;
                        end else begin
                            node_link[x] = c;
                            if (p == NIL) list_head = x;
                            else node_link[p] = x;
                        end
                    end
                end
            end
            M_RM_HEAD: begin
                if (list_head == NIL) st = ST_EMPTY;
                else unlink_node(NIL, list_head);
            end
            M_RM_TAIL: begin
                if (list_head == NIL) st = ST_EMPTY;
                else begin
                    p = NIL;
                    c = list_head;
                    while (node_link[c] != NIL) begin
                        p = c;
                        c = node_link[c];
                    end
                    unlink_node(p, c);
                end
            end
            M_RM_AFTER: begin
                if (list_head == NIL) st = ST_EMPTY;
                else begin
                    find_first(key, c, p);
                    if (c == NIL || node_link[c] == NIL) st = ST_NOTFOUND;
                    else unlink_node(c, node_link[c]);
                end
            end
            M_RM_BEFORE: begin
                if (list_head == NIL) st = ST_EMPTY;
                else begin
                    find_first(key, c, p);
                    if (c == NIL || p == NIL) st = ST_NOTFOUND;
                    else begin
                        pp = NIL;
                        q = list_head;
                        while (q != p) begin
                            pp = q;
                            q = node_link[q];
                        end
                        unlink_node(pp, p);
                    end
                end
            end
            default: ;
        endcase
        pending_beats.push_back('{st, '0, 1'b1});
    endtask

    task automatic send_op(input logic [3:0] mode, input logic [DATA_WIDTH-1:0] key,
                           input logic [DATA_WIDTH-1:0] val);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 99) < 16) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_mode = mode;
        i_key = key;
        i_value = val;
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_op(mode, key, val);
    endtask

    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n && o_strobe) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat status", o_status, 0);
            end else begin
                want = pending_beats.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_data !== want.data) report_mismatch("data", o_data, want.data);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) stall_count <= 0;
            else stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("watchdog expired");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic test_empty_list();
        send_op(M_DUMP, 16'h0, 16'h0);
        send_op(M_REMOVE, 16'h0, 16'h0);
        send_op(M_RM_HEAD, 16'h0, 16'h0);
        send_op(M_RM_TAIL, 16'h0, 16'h0);
        send_op(M_RM_AFTER, 16'h0, 16'h0);
        send_op(M_RM_BEFORE, 16'h0, 16'h0);
        send_op(M_INS_AFTER, 16'h0, 16'h1);
        send_op(M_INS_BEFORE, 16'h0, 16'h1);
    endtask

    task automatic test_basic_ops();
        send_op(M_INS_HEAD, 16'h0, 16'h0000);
        send_op(M_INS_TAIL, 16'hffff, 16'hffff);
        send_op(M_INS_AFTER, 16'h1234, 16'h5);
        send_op(M_INS_AFTER, 16'h0000, 16'h5);
        send_op(M_INS_BEFORE, 16'h0000, 16'ha5a5);
        send_op(M_RM_AFTER, 16'hffff, 16'h0);
        send_op(M_RM_BEFORE, 16'ha5a5, 16'h0);
        send_op(M_RM_BEFORE, 16'h0005, 16'h0);
        send_op(M_DUMP, 16'h0, 16'h0);
        send_op(M_RM_AFTER, 16'ha5a5, 16'h0);
        send_op(M_REMOVE, 16'h0, 16'h7777);
        send_op(M_REMOVE, 16'h0, 16'ha5a5);
        send_op(4'd10, 16'hffff, 16'hffff);
        send_op(4'd15, 16'h0, 16'h0);
        send_op(M_RM_TAIL, 16'h0, 16'h0);
        send_op(M_RM_HEAD, 16'h0, 16'h0);
        send_op(M_DUMP, 16'h0, 16'h0);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < NODES; i++)
            send_op(i[0] ? M_INS_TAIL : M_INS_HEAD, 16'h0, DATA_WIDTH'(i * 16'h0401));
        send_op(M_INS_HEAD, 16'h0, 16'h1);
        send_op(M_INS_TAIL, 16'h0, 16'h1);
        send_op(M_INS_AFTER, 16'hbeef, 16'h1);
        send_op(M_INS_BEFORE, 16'h0000, 16'h1);
        send_op(M_DUMP, 16'h0, 16'h0);
        for (int i = 0; i < NODES; i++)
            send_op(i[0] ? M_RM_TAIL : M_RM_HEAD, 16'h0, 16'h0);
        send_op(M_DUMP, 16'h0, 16'h0);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        if ($urandom_range(0, 3) == 0) return DATA_WIDTH'($urandom_range(0, 65535));
        return DATA_WIDTH'($urandom_range(0, 7));
    endfunction

    task automatic test_random_ops();
        logic [3:0] mode;
        int         roll;
        for (int i = 0; i < 211; i++) begin
            gaps_on = !(i >= 80 && i < 160);
            roll = $urandom_range(0, 99);
            if (roll < 3) mode = 4'($urandom_range(10, 15));
            else if (roll < 10) mode = M_DUMP;
            else if ((i / 60) % 2 == 0) mode = 4'(roll < 55 ? $urandom_range(0, 4)
                                                         : $urandom_range(0, 8));
            else mode = 4'(roll < 55 ? $urandom_range(5, 8) : $urandom_range(0, 8));
            send_op(mode, pick_word(), pick_word());
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        list_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_list();
        test_basic_ops();
        test_full_store();
        test_random_ops();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (NODES + 16) @(posedge i_clk);
        if (pending_beats.size() != 0) report_mismatch("leftover beats", pending_beats.size(), 0);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/all_pkg.sv
hw/rtl/all_datapath.sv
hw/rtl/all_controller.sv
hw/rtl/array_linked_list_engine.sv
test/array_linked_list_engine_test.sv
